// ----- rtl/core/mlpc_pkg.sv -----
// Shared types and constants of the multi-line profile combine unit.
// No dependencies; imported by every module of the block.
package mlpc_pkg;

	localparam int LANES = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int CNT_W = 4;
	localparam int MODE_W = 3;
	localparam int IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam int DIV_STEP_BITS = 4;

	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MEAN = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MAX = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MIN = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd4;

	localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_COUNT = 2'd1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0] cnt;
	} cfg_t;

endpackage

// ----- rtl/core/mlpc_ctrl.sv -----
// Valid tracking and per-stage load enables of the combine pipeline.
// Depends on mlpc_pkg; a stall reaches back combinationally through full stages and stops at the first empty slot.
module mlpc_ctrl import mlpc_pkg::*; #(
	parameter int NST = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [NST-1:0] en
);

	logic [NST-1:0] vld_q;
	logic [NST:0] rdy;

	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign en = rdy[NST-1:0];
	assign in_stall = !rdy[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

endmodule

// ----- rtl/core/mlpc_lane.sv -----
// One lane: ranks its own sample among the active samples, ties broken by lane order.
// Depends on mlpc_pkg; holds the lane's value and rank for the merge stage.
module mlpc_lane import mlpc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [LANE_W-1:0]      own_idx,
	input  logic [SAMPLE_BITS-1:0] own_val,
	input  logic [SAMPLE_BITS-1:0] vals [LANES],
	input  logic [LANES-1:0]       act,
	output logic [SAMPLE_BITS-1:0] val_s2,
	output logic [LANE_W-1:0]      rank_s2
);

	logic [LANE_W-1:0] rank;

	always_comb begin
		rank = '0;
		for (int j = 0; j < LANES; j++) begin
			if (act[j] && ((vals[j] < own_val) ||
				((vals[j] == own_val) && (LANE_W'(j) < own_idx)))) begin
				rank = rank + LANE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2 <= own_val;
			rank_s2 <= rank;
		end
	end

endmodule

// ----- rtl/core/mlpc_merge.sv -----
// Merge of the lane results: picks the ranked values and sums the active lanes,
// then forms dividend and divisor. Depends on mlpc_pkg.
module mlpc_merge import mlpc_pkg::*; #(
	parameter int SAMPLE_BITS = 16,
	localparam int SUM_W = SAMPLE_BITS + LANE_W
) (
	input  logic                   clk,
	input  logic                   en3,
	input  logic                   en4,
	input  cfg_t                   cfg_s2,
	input  logic [SAMPLE_BITS-1:0] val_s2 [LANES],
	input  logic [LANE_W-1:0]      rank_s2 [LANES],
	output logic [SUM_W-1:0]       dividend_s4,
	output logic [CNT_W-1:0]       divisor_s4
);

	localparam int PAIRS = LANES / 2;

	logic [LANES-1:0] act;
	logic use_first;
	logic [LANE_W-1:0] r_lo, r_hi;
	logic [SAMPLE_BITS-1:0] lo, hi;
	logic [SAMPLE_BITS:0] psum [PAIRS];
	logic [SAMPLE_BITS-1:0] masked [LANES];

	logic [SAMPLE_BITS-1:0] lo_s3, hi_s3;
	logic [SAMPLE_BITS:0] psum_s3 [PAIRS];
	logic mean_s3;
	logic [CNT_W-1:0] cnt_s3;

	logic [SUM_W-1:0] total;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			act[i] = CNT_W'(i) < cfg_s2.cnt;
			masked[i] = act[i] ? val_s2[i] : '0;
		end
		for (int p = 0; p < PAIRS; p++) begin
			psum[p] = {1'b0, masked[2*p]} + {1'b0, masked[2*p+1]};
		end
	end

	always_comb begin
		use_first = (cfg_s2.cnt == CNT_W'(1));
		r_hi = LANE_W'(cfg_s2.cnt >> 1);
		r_lo = r_hi;
		case (cfg_s2.mode)
			MODE_MAX: begin
				r_lo = LANE_W'(cfg_s2.cnt - CNT_W'(1));
				r_hi = r_lo;
			end
			MODE_MIN: begin
				r_lo = '0;
				r_hi = '0;
			end
			MODE_MEDIAN: begin
				if (!cfg_s2.cnt[0]) begin
					r_lo = r_hi - LANE_W'(1);
				end
			end
			default: begin
				use_first = 1'b1;
			end
		endcase
	end

	always_comb begin
		lo = '0;
		hi = '0;
		for (int i = 0; i < LANES; i++) begin
			if (act[i] && (rank_s2[i] == r_lo)) begin
				lo = lo | val_s2[i];
			end
			if (act[i] && (rank_s2[i] == r_hi)) begin
				hi = hi | val_s2[i];
			end
		end
		if (use_first) begin
			lo = val_s2[0];
			hi = val_s2[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			lo_s3 <= lo;
			hi_s3 <= hi;
			psum_s3 <= psum;
			mean_s3 <= (cfg_s2.mode == MODE_MEAN);
			cnt_s3 <= cfg_s2.cnt;
		end
	end

	always_comb begin
		total = '0;
		for (int p = 0; p < PAIRS; p++) begin
			total = total + SUM_W'(psum_s3[p]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			if (mean_s3) begin
				dividend_s4 <= total;
				divisor_s4 <= cnt_s3;
			end else begin
				dividend_s4 <= SUM_W'({1'b0, lo_s3} + {1'b0, hi_s3});
				divisor_s4 <= CNT_W'(2);
			end
		end
	end

endmodule

// ----- rtl/core/mlpc_div.sv -----
// Pipelined restoring divider by a small count, DIV_STEP_BITS (4) quotient bits per stage.
// Depends on mlpc_pkg; the last stage is the block's output register.
module mlpc_div import mlpc_pkg::*; #(
	parameter int SUM_W = 19,
	parameter int Q_W = 16,
	localparam int DS = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS
) (
	input  logic             clk,
	input  logic [DS-1:0]    en,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [Q_W-1:0]   quotient
);

	localparam int PW = DS * DIV_STEP_BITS;

	logic [PW-1:0] work_q [DS];
	logic [LANE_W-1:0] rem_q [DS];
	logic [CNT_W-1:0] dvs_q [DS];

	for (genvar k = 0; k < DS; k++) begin : g_stage
		logic [PW-1:0] w_in, w;
		logic [LANE_W-1:0] r_in, r;
		logic [CNT_W-1:0] d_in, t;

		if (k == 0) begin : g_first
			assign w_in = PW'(dividend);
			assign r_in = '0;
			assign d_in = divisor;
		end else begin : g_next
			assign w_in = work_q[k-1];
			assign r_in = rem_q[k-1];
			assign d_in = dvs_q[k-1];
		end

		always_comb begin
			w = w_in;
			r = r_in;
			t = '0;
			for (int b = 0; b < DIV_STEP_BITS; b++) begin
				t = CNT_W'({r, w[PW-1]});
				if (t >= d_in) begin
					r = LANE_W'(t - d_in);
					w = {w[PW-2:0], 1'b1};
				end else begin
					r = LANE_W'(t);
					w = {w[PW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				work_q[k] <= w;
				rem_q[k] <= r;
				dvs_q[k] <= d_in;
			end
		end
	end

	assign quotient = work_q[DS-1][Q_W-1:0];

endmodule

// ----- rtl/core/multi_line_profile_combine_unit.sv -----
// Top level of the multi-line profile combine unit: config registers, input stage,
// lanes, merge and divider. Depends on mlpc_pkg, mlpc_ctrl, mlpc_lane, mlpc_merge, mlpc_div.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in       | to block  | in_valid / in_stall   | lane_value_0 .. lane_value_7
//  out      | from block| out_valid / out_stall | combined_value
//  cfg      | to block  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word in and one word out per cycle when nothing stalls.
// The pipeline is made of the input, rank, select and sum stages followed by
// the divider, which takes 4 quotient bits per stage.
// Reset clears the valid bits and loads combine_mode 0 and line_count 8.
// A stall at the output holds the last stage; earlier stages keep filling empty slots.
module multi_line_profile_combine_unit import mlpc_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] lane_value_0,
	input  logic [SAMPLE_BITS-1:0] lane_value_1,
	input  logic [SAMPLE_BITS-1:0] lane_value_2,
	input  logic [SAMPLE_BITS-1:0] lane_value_3,
	input  logic [SAMPLE_BITS-1:0] lane_value_4,
	input  logic [SAMPLE_BITS-1:0] lane_value_5,
	input  logic [SAMPLE_BITS-1:0] lane_value_6,
	input  logic [SAMPLE_BITS-1:0] lane_value_7,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SAMPLE_BITS-1:0] combined_value,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int SUM_W = SAMPLE_BITS + LANE_W;
	localparam int DS = (SUM_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
	localparam int NST = 4 + DS;

	logic [MODE_W-1:0] combine_mode_q;
	logic [CNT_W-1:0] line_count_q;
	logic [CNT_W-1:0] cnt_clamped;

	logic [NST-1:0] en;

	logic [SAMPLE_BITS-1:0] lane_in [LANES];
	logic [SAMPLE_BITS-1:0] lane_s1 [LANES];
	cfg_t cfg_s1, cfg_s2;
	logic [LANES-1:0] act_s1;

	logic [SAMPLE_BITS-1:0] val_s2 [LANES];
	logic [LANE_W-1:0] rank_s2 [LANES];

	logic [SUM_W-1:0] dividend_s4;
	logic [CNT_W-1:0] divisor_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			combine_mode_q <= MODE_FIRST;
			line_count_q <= CNT_W'(LANES);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE: combine_mode_q <= cfg_data[MODE_W-1:0];
				REG_COUNT: line_count_q <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cnt_clamped = line_count_q;
		if (line_count_q == '0) begin
			cnt_clamped = CNT_W'(1);
		end else if (line_count_q > CNT_W'(LANES)) begin
			cnt_clamped = CNT_W'(LANES);
		end
	end

	assign lane_in[0] = lane_value_0;
	assign lane_in[1] = lane_value_1;
	assign lane_in[2] = lane_value_2;
	assign lane_in[3] = lane_value_3;
	assign lane_in[4] = lane_value_4;
	assign lane_in[5] = lane_value_5;
	assign lane_in[6] = lane_value_6;
	assign lane_in[7] = lane_value_7;

	mlpc_ctrl #(
		.NST(NST)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.en(en)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			lane_s1 <= lane_in;
			cfg_s1.mode <= combine_mode_q;
			cfg_s1.cnt <= cnt_clamped;
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			act_s1[i] = CNT_W'(i) < cfg_s1.cnt;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mlpc_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk(clk),
			.en(en[1]),
			.own_idx(LANE_W'(i)),
			.own_val(lane_s1[i]),
			.vals(lane_s1),
			.act(act_s1),
			.val_s2(val_s2[i]),
			.rank_s2(rank_s2[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cfg_s2 <= cfg_s1;
		end
	end

	mlpc_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk(clk),
		.en3(en[2]),
		.en4(en[3]),
		.cfg_s2(cfg_s2),
		.val_s2(val_s2),
		.rank_s2(rank_s2),
		.dividend_s4(dividend_s4),
		.divisor_s4(divisor_s4)
	);

	mlpc_div #(
		.SUM_W(SUM_W),
		.Q_W(SAMPLE_BITS)
	) u_div (
		.clk(clk),
		.en(en[NST-1:4]),
		.dividend(dividend_s4),
		.divisor(divisor_s4),
		.quotient(combined_value)
	);

endmodule
